// ===== sv/rsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rsp_pkg: shared types and constants for the run-length sprite decoder
// Transaction payloads, register indexes, input kinds and parse phases.
// ----------------------------------------------------------------------------
`default_nettype none

package rsp_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int DIM_W         = 15;
  localparam int CFG_ADDR_W    = 1;
  localparam int CFG_DATA_W    = 15;
  localparam int COLOR_W       = 24;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  localparam logic [CFG_ADDR_W-1:0] REG_PIC_WIDTH  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PIC_HEIGHT = 1'd1;

  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_BODY    = 1'b1;

  typedef enum logic [3:0] {
    PH_ROWLEN     = 4'b0001,
    PH_SKIP       = 4'b0010,
    PH_SOLIDCOUNT = 4'b0100,
    PH_SOLID      = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
    logic [5:0] red_six;
    logic [5:0] green_six;
    logic [5:0] blue_six;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] pixel_column;
    logic [DIM_W-1:0] pixel_row;
    logic [31:0]      argb;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/rle_sprite_palette_decoder.sv =====
// ----------------------------------------------------------------------------
// rle_sprite_palette_decoder: run-length sprite body to opaque ARGB pixels
// Parses row-length, skip and solid counts and looks up palette colors.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data): kind selects a palette write
//   (byte_value is the index, three 6-bit channels scaled by 4) or a body
//   byte. last_byte on a body byte returns the parser to its reset state.
//   out channel (out_valid/out_ready/out_data): one transaction per opaque
//   pixel with its column, row and ARGB color (alpha 0xff).
//   cfg port (cfg_we/cfg_addr/cfg_wdata): pic_width at index 0, pic_height
//   at index 1; write only while the block is idle.
// Throughput: one input transaction per cycle while in_ready is high. Parse
//   state updates in the accept cycle; the palette read registers the color
//   into the read-data stage, then the output register presents the pixel.
// Stall: a read-data stage and the output register hold up to two pixels;
//   in_ready drops only when both are full and out_ready is low.
// Reset: clears parse state, registers, pipeline valids and the palette
//   entry valid bits, so every palette entry reads as zero until written.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_sprite_palette_decoder #(
  parameter int PaletteDepth = rsp_pkg::PALETTE_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [rsp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [rsp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire rsp_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output rsp_pkg::out_item_t                      out_data
);
  import rsp_pkg::*;

  localparam int IdxW = $clog2(PaletteDepth);

  // configuration
  logic [DIM_W-1:0] pic_width;
  logic [DIM_W-1:0] pic_height;

  // parse state
  phase_t           phase, phase_next;
  logic [15:0]      column, column_next;
  logic [DIM_W-1:0] row_index, row_index_next;
  logic [7:0]       row_length, row_length_next;
  logic [7:0]       solid_left, solid_left_next;
  logic [7:0]       rel_count, rel_count_next;
  logic             stopped, stopped_next;

  // palette and pipeline
  logic [COLOR_W-1:0] palette_mem [PaletteDepth];
  logic [PaletteDepth-1:0] pal_valid;
  logic [COLOR_W-1:0] rd_data;
  logic               rd_ok;
  logic               p1_valid;
  logic [DIM_W-1:0]   p1_col;
  logic [DIM_W-1:0]   p1_row;
  logic               p1_adv;

  logic               in_fire;
  logic               body_fire;
  logic               emit;
  logic               rd_en;
  logic               took_rl;
  logic               do_finish;
  logic [15:0]        fin_col;
  logic [15:0]        col_sum;
  logic [15:0]        col_inc;
  logic [7:0]         solid_dec;
  logic [DIM_W-1:0]   row_p1;
  logic [DIM_W-1:0]   row_p2;
  logic [15:0]        width_ext;
  logic               idx_in_range;
  logic [IdxW-1:0]    idx;
  logic [8:0]         rel_p1;

  assign in_fire      = in_valid && in_ready;
  assign body_fire    = in_fire && (in_data.kind == KIND_BODY);
  assign idx_in_range = ({1'b0, in_data.byte_value} < 9'(PaletteDepth));
  assign idx          = in_data.byte_value[IdxW-1:0];
  assign width_ext    = {1'b0, pic_width};
  assign col_sum      = column + 16'(in_data.byte_value);
  assign col_inc      = column + 16'd1;
  assign solid_dec    = solid_left - 8'd1;
  assign row_p1       = row_index + 15'd1;
  assign row_p2       = row_index + 15'd2;
  assign rel_p1       = {1'b0, rel_count} + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pic_width  <= '0;
      pic_height <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PIC_WIDTH:  pic_width  <= cfg_wdata;
        REG_PIC_HEIGHT: pic_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next      = phase;
    column_next     = column;
    row_index_next  = row_index;
    row_length_next = row_length;
    solid_left_next = solid_left;
    rel_count_next  = rel_count;
    stopped_next    = stopped;
    emit            = 1'b0;
    took_rl         = 1'b0;
    do_finish       = 1'b0;
    fin_col         = column;
    if (body_fire) begin
      if (!stopped) begin
        unique case (phase)
          PH_SKIP: begin
            column_next = col_sum;
            if (col_sum >= width_ext) begin
              // end the row, then reread this byte as the next row length
              row_index_next = row_p1;
              phase_next     = PH_ROWLEN;
              if (row_p1 >= pic_height) begin
                stopped_next = 1'b1;
              end else begin
                row_length_next = in_data.byte_value;
                took_rl         = 1'b1;
                if (in_data.byte_value == 8'd0) begin
                  row_index_next = row_p2;
                  stopped_next   = (row_p2 >= pic_height);
                end else begin
                  column_next = '0;
                  phase_next  = PH_SKIP;
                end
              end
            end else begin
              phase_next = PH_SOLIDCOUNT;
            end
          end
          PH_SOLIDCOUNT: begin
            solid_left_next = in_data.byte_value;
            if (in_data.byte_value == 8'd0) begin
              do_finish = 1'b1;
            end else begin
              phase_next = PH_SOLID;
            end
          end
          PH_SOLID: begin
            emit            = (column < width_ext);
            column_next     = col_inc;
            solid_left_next = solid_dec;
            fin_col         = col_inc;
            do_finish       = (solid_dec == 8'd0);
          end
          PH_ROWLEN: begin
            if (row_index >= pic_height) begin
              stopped_next = 1'b1;
            end else begin
              row_length_next = in_data.byte_value;
              took_rl         = 1'b1;
              if (in_data.byte_value == 8'd0) begin
                row_index_next = row_p1;
                stopped_next   = (row_p1 >= pic_height);
              end else begin
                column_next = '0;
                phase_next  = PH_SKIP;
              end
            end
          end
          default: ;
        endcase
        if (do_finish) begin
          if ((fin_col >= width_ext) || (rel_p1 >= {1'b0, row_length})) begin
            row_index_next = row_p1;
            phase_next     = PH_ROWLEN;
            stopped_next   = (row_p1 >= pic_height);
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      // bytes since the row-length byte, saturated; only compared to 8 bits
      if (took_rl) begin
        rel_count_next = 8'd1;
      end else if (rel_count != 8'hff) begin
        rel_count_next = rel_p1[7:0];
      end
      if (in_data.last_byte) begin
        phase_next      = PH_ROWLEN;
        column_next     = '0;
        row_index_next  = '0;
        row_length_next = '0;
        solid_left_next = '0;
        rel_count_next  = '0;
        stopped_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_ROWLEN;
      column     <= '0;
      row_index  <= '0;
      row_length <= '0;
      solid_left <= '0;
      rel_count  <= '0;
      stopped    <= 1'b0;
    end else begin
      phase      <= phase_next;
      column     <= column_next;
      row_index  <= row_index_next;
      row_length <= row_length_next;
      solid_left <= solid_left_next;
      rel_count  <= rel_count_next;
      stopped    <= stopped_next;
    end
  end

  // palette memory: write on palette transactions, read on emitted pixels
  assign rd_en = emit;

  always_ff @(posedge clk) begin
    if (in_fire && (in_data.kind == KIND_PALETTE) && idx_in_range) begin
      palette_mem[idx] <= {in_data.red_six, 2'b00, in_data.green_six, 2'b00,
                           in_data.blue_six, 2'b00};
    end
    if (rd_en) begin
      rd_data <= palette_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (in_fire && (in_data.kind == KIND_PALETTE) && idx_in_range) begin
        pal_valid[idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= idx_in_range && pal_valid[idx];
      end
    end
  end

  // read-data stage and output register
  assign p1_adv   = p1_valid && (!out_valid || out_ready);
  assign in_ready = !p1_valid || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (rd_en) begin
      p1_valid <= 1'b1;
    end else if (p1_adv) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      p1_col <= column[DIM_W-1:0];
      p1_row <= row_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      out_data.pixel_column <= p1_col;
      out_data.pixel_row    <= p1_row;
      out_data.argb         <= {ALPHA_OPAQUE, rd_ok ? rd_data : {COLOR_W{1'b0}}};
    end
  end

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (p1_valid && out_valid && !out_ready))
    else $error("input stalled without a full pipeline");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (body_fire && in_data.last_byte) |=>
      ((phase == PH_ROWLEN) && !stopped && (row_index == '0) && (rel_count == '0)))
    else $error("last byte did not rearm the parser");

  a_read_stage: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (p1_valid && (p1_col == $past(column[DIM_W-1:0]))
               && (p1_row == $past(row_index))))
    else $error("read stage lost a pixel");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !p1_valid && (pal_valid == '0)))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
